/* hdl/signed_decimal_segment_writer_assert.svh */
// Assertion macros for the segment writer.
`ifndef SIGNED_DECIMAL_SEGMENT_WRITER_ASSERT_SVH
`define SIGNED_DECIMAL_SEGMENT_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment writer check failed");

// Next-cycle implication, checked outside reset.
`define SDSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment writer check failed");

`endif

/* hdl/sdsw_pkg.sv */
package sdsw_pkg;

    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned ADDR_W       = 12;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned BCD_DIGITS   = 10;
    localparam int unsigned BCD_W        = 4 * BCD_DIGITS;
    localparam int unsigned POSITIONS    = 6;
    localparam int unsigned POS_IDX_W    = $clog2(POSITIONS);
    localparam int unsigned BIT_CNT_W    = $clog2(VALUE_W);
    localparam int unsigned NUM_DIGITS_DEF = 6;

    localparam logic [ADDR_W-1:0] MINUS_ADDR = 12'h A2A;
    localparam logic [DATA_W-1:0] MINUS_DATA = 8'h04;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGIT
    } t_state;

    function automatic logic [ADDR_W-1:0] pos_addr(input logic [POS_IDX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        case (idx)
            3'd0:    a = 12'h A27;
            3'd1:    a = 12'h A2E;
            3'd2:    a = 12'h A32;
            3'd3:    a = 12'h A23;
            3'd4:    a = 12'h A25;
            3'd5:    a = 12'h A29;
            default: a = 12'h A27;
        endcase
        return a;
    endfunction

    function automatic logic [DATA_W-1:0] digit_pattern(input logic [3:0] d);
        logic [DATA_W-1:0] p;
        case (d)
            4'd0:    p = 8'h FC;
            4'd1:    p = 8'h 60;
            4'd2:    p = 8'h DB;
            4'd3:    p = 8'h F3;
            4'd4:    p = 8'h 67;
            4'd5:    p = 8'h B7;
            4'd6:    p = 8'h BF;
            4'd7:    p = 8'h E4;
            4'd8:    p = 8'h FF;
            4'd9:    p = 8'h F7;
            default: p = 8'h FC;
        endcase
        return p;
    endfunction

    // Double-dabble: add 3 to every BCD digit of 5 or more.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (b[4*k +: 4] >= 4'd5) begin
                r[4*k +: 4] = b[4*k +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

/* hdl/signed_decimal_segment_writer.sv */
// After start is taken, the magnitude is converted one bit per cycle in a double-dabble BCD
// shifter (S_CONV); each write is then formed in S_SIGN or S_DIGIT and output registered.
// A new value is taken only in idle, after conversion and all writes (1 to 7 writes);
// busy covers conversion and writes.
// Writes come one per cycle on o_strobe; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) returns to idle and drops o_strobe; nothing else is cleared.
`include "signed_decimal_segment_writer_assert.svh"

module signed_decimal_segment_writer #(
    parameter int unsigned NUM_DIGITS = sdsw_pkg::NUM_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [sdsw_pkg::VALUE_W-1:0] i_value,
    output logic                           o_strobe,
    output logic [sdsw_pkg::ADDR_W-1:0]    o_seg_address,
    output logic [sdsw_pkg::DATA_W-1:0]    o_seg_data,
    output logic                           o_last
);
    import sdsw_pkg::*;

    localparam int unsigned LIM = (NUM_DIGITS > POSITIONS) ? POSITIONS :
                                  ((NUM_DIGITS < 1) ? 1 : NUM_DIGITS);
    localparam logic [POS_IDX_W-1:0] LAST_IDX = POS_IDX_W'(LIM - 1);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_W - 1);

    t_state                r_state, n_state;
    logic [VALUE_W-1:0]    r_mag, n_mag;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [BIT_CNT_W-1:0]  r_bit, n_bit;
    logic [POS_IDX_W-1:0]  r_idx, n_idx;
    logic                  r_strobe, n_strobe;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [DATA_W-1:0]     r_data, n_data;
    logic                  r_last, n_last;
    logic                  digit_done;
    logic [BCD_W-1:0]      bcd_adj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_bit  <= n_bit;
        r_idx  <= n_idx;
        r_addr <= n_addr;
        r_data <= n_data;
        r_last <= n_last;
    end

    assign digit_done = (r_bcd[BCD_W-1:4] == '0) || (r_idx == LAST_IDX);
    assign bcd_adj    = dabble(r_bcd);

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_bcd    = r_bcd;
        n_neg    = r_neg;
        n_bit    = r_bit;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_addr   = r_addr;
        n_data   = r_data;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_neg   = i_value[VALUE_W-1];
                    n_mag   = i_value[VALUE_W-1] ? (~i_value) + 1'b1 : i_value;
                    n_bcd   = '0;
                    n_bit   = '0;
                    n_idx   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_mag[VALUE_W-1]};
                n_mag = {r_mag[VALUE_W-2:0], 1'b0};
                n_bit = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_addr   = MINUS_ADDR;
                n_data   = MINUS_DATA;
                n_last   = 1'b0;
                n_state  = S_DIGIT;
            end
            S_DIGIT: begin
                n_strobe = 1'b1;
                n_addr   = pos_addr(r_idx);
                n_data   = digit_pattern(r_bcd[3:0]);
                n_last   = digit_done;
                n_bcd    = {4'd0, r_bcd[BCD_W-1:4]};
                n_idx    = r_idx + 1'b1;
                if (digit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_seg_address = r_addr;
    assign o_seg_data    = r_data;
    assign o_last        = r_last;

    `SDSW_ASSERT_NEXT(a_start_conv, i_clk, i_rst_n, start && !busy, r_state == S_CONV)
    `SDSW_ASSERT_NOW(a_quiet_conv, i_clk, i_rst_n,
        r_state == S_CONV && $past(r_state) == S_CONV, !o_strobe)
    `SDSW_ASSERT_NOW(a_more_busy, i_clk, i_rst_n, o_strobe && !o_last, busy)

endmodule

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdsw_pkg::*;

    localparam int unsigned NUM_DIGITS   = NUM_DIGITS_DEF;
    localparam int          DIGIT_LIMIT  = (NUM_DIGITS > 6) ? 6 : ((NUM_DIGITS < 1) ? 1 :
                                           int'(NUM_DIGITS));
    localparam int          RANDOM_ITEMS = 388;
    localparam int          QUIET_FIRST  = 120;
    localparam int          QUIET_LAST   = 230;
    localparam int          DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_seg_write;

    localparam logic [ADDR_W-1:0] DIGIT_ADDR [6] = '{
        12'hA27, 12'hA2E, 12'hA32, 12'hA23, 12'hA25, 12'hA29
    };
    localparam logic [DATA_W-1:0] SEG_GLYPH [10] = '{
        8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE4, 8'hFF, 8'hF7
    };

    class segment_scoreboard;
        t_seg_write pending_writes[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Expand one accepted value into the writes it should cause.
        function void note_value(logic [VALUE_W-1:0] v);
            logic [VALUE_W-1:0] mag;
            int unsigned        dgt;
            int                 pos;
            bit                 done;
            t_seg_write         w;
            mag = v;
            if (v[VALUE_W-1]) begin
                w.addr = MINUS_ADDR;
                w.data = MINUS_DATA;
                w.last = 1'b0;
                pending_writes.push_back(w);
                mag = ~v + 1'b1;
            end
            pos = 0;
            do begin
                dgt  = mag % 10;
                mag  = mag / 10;
                pos++;
                done = (mag == 0) || (pos >= DIGIT_LIMIT);
                w.addr = DIGIT_ADDR[pos-1];
                w.data = SEG_GLYPH[dgt];
                w.last = done;
                pending_writes.push_back(w);
            end while (!done);
        endfunction

        task check_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data, logic last);
            t_seg_write exp_w;
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write addr=%h data=%h last=%b",
                                          addr, data, last));
            end else begin
                exp_w = pending_writes.pop_front();
                if (addr !== exp_w.addr)
                    report_mismatch($sformatf("addr %h, want %h", addr, exp_w.addr));
                if (data !== exp_w.data)
                    report_mismatch($sformatf("data %h, want %h (addr %h)",
                                              data, exp_w.data, exp_w.addr));
                if (last !== exp_w.last)
                    report_mismatch($sformatf("last %b, want %b (addr %h)",
                                              last, exp_w.last, exp_w.addr));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [VALUE_W-1:0]  i_value;
    logic                o_strobe;
    logic [ADDR_W-1:0]   o_seg_address;
    logic [DATA_W-1:0]   o_seg_data;
    logic                o_last;

    segment_scoreboard sb;

    signed_decimal_segment_writer #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_seg_address (o_seg_address),
        .o_seg_data    (o_seg_data),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #600000;
        $display("Simulation FAILED");
        $finish;
    end

    // Hold start high until the beat is taken.
    task send_value(logic [VALUE_W-1:0] v);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        sb.note_value(v);
    endtask

    task idle_cycles(int n);
        @(negedge i_clk);
        start   <= 1'b0;
        i_value <= $urandom();
        repeat (n) @(posedge i_clk);
    endtask

    task wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] mag;
        int unsigned        pick;
        int unsigned        k;
        int unsigned        pow10;
        pick = $urandom_range(0, 9);
        k    = $urandom_range(0, 9);
        pow10 = 1;
        repeat (k) pow10 = pow10 * 10;
        case (pick)
            0, 1, 2: mag = $urandom();
            3, 4, 5, 6: mag = $urandom_range(0, ((k > 7) ? 10000000 : pow10) - 1);
            7, 8: mag = pow10 - $urandom_range(0, 1);
            default: begin
                case ($urandom_range(0, 3))
                    0: mag = 32'h8000_0000;
                    1: mag = 32'h7FFF_FFFF;
                    2: mag = 32'hFFFF_FFFF;
                    default: mag = '0;
                endcase
            end
        endcase
        if (pick >= 3 && pick <= 8 && $urandom_range(0, 1))
            mag = -mag;
        return mag;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_write(o_seg_address, o_seg_data, o_last);
    end

    initial begin
        logic [VALUE_W-1:0] directed [$];
        int                 n;
        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        directed = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd7, -32'sd5,
            32'd99999, 32'd100000, 32'd999999, 32'd1000000, -32'sd999999,
            -32'sd1000000, 32'd123456, -32'sd123456, 32'd12345678, 32'd1234567890,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'd8
        };
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[j]) begin
            if (j % 4 == 3)
                idle_cycles($urandom_range(1, 45));
            send_value(directed[j]);
        end

        // Let the block drain fully before the random part.
        idle_cycles(1);
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) begin
                idle_cycles(1);
                wait_drained();
            end
            if ((n < QUIET_FIRST || n > QUIET_LAST) && $urandom_range(0, 99) < 20)
                idle_cycles($urandom_range(1, 30));
            send_value(random_value());
        end

        idle_cycles(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/sdsw_pkg.sv
hdl/signed_decimal_segment_writer.sv
verif/tb.sv
